/* rtl/bbc_pkg.sv */
// bbc_pkg: shared constants for the band-pass biquad cascade
// coefficient format, configuration register indexes and term codes
// no dependencies
package bbc_pkg;

    // coefficient registers are signed, fixed at 32 bits
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HP_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HP_A1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HP_A2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LP_B0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LP_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LP_A2 = 3'd5;

    // per-section multiply-accumulate terms, in issue order
    localparam int TERM_W = 3;
    localparam logic [TERM_W-1:0] TERM_X0 = 3'd0;
    localparam logic [TERM_W-1:0] TERM_X1 = 3'd1;
    localparam logic [TERM_W-1:0] TERM_X2 = 3'd2;
    localparam logic [TERM_W-1:0] TERM_Y1 = 3'd3;
    localparam logic [TERM_W-1:0] TERM_Y2 = 3'd4;

    // section select
    localparam logic SECT_HP = 1'b0;
    localparam logic SECT_LP = 1'b1;

endpackage

/* rtl/bbc_if.sv */
// bbc_if: valid/ready channels carrying one audio sample per request
// sample_in_if feeds the filter, sample_out_if carries its result
// no dependencies
interface sample_in_if #(
    parameter int WIDTH = 24
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface sample_out_if #(
    parameter int WIDTH = 24
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/biquad_bandpass_cascade.sv */
// biquad_bandpass_cascade: high-pass biquad followed by low-pass biquad, direct form I
// depends on bbc_pkg and the channel interfaces in bbc_if.sv
//
// in_ch carries one signed sample per request, out_ch returns one filtered sample
// per request. coefficients (Q2.30 by default) are written through cfg_we, cfg_index
// and cfg_data while no request is in flight; an unknown index is ignored.
// one signed 32 x SAMPLE_BITS multiplier with a registered product is shared by all
// ten terms of both sections; a small sequencer issues five products per section,
// adds each into a wide accumulator in the next cycle, then rounds and saturates.
// a request is taken only when the sequencer is idle, and its result is loaded into
// the out_ch output register after the low-pass rounding step; only then does the
// sequencer return to idle, so no new sample is taken before the last one is through.
// the result sits in an output register: the next request is still accepted while
// out_ch is stalled, and the sequencer waits at the last rounding step until the
// output register is free.
// reset clears all coefficients, the sample histories and the output valid.
module biquad_bandpass_cascade
    import bbc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 30
)(
    input  logic                 clk,
    input  logic                 rst_n,
    sample_in_if.sink            in_ch,
    sample_out_if.source         out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam int Q_W    = ACC_W - COEF_FRAC_BITS;

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MAC   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic signed [ACC_W-1:0] ROUND_CONST =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0] SAT_MAX = {{(Q_W-SAMPLE_BITS+1){1'b0}},
                                                 {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [Q_W-1:0] SAT_MIN = {{(Q_W-SAMPLE_BITS+1){1'b1}},
                                                 {(SAMPLE_BITS-1){1'b0}}};

    // coefficient registers
    logic signed [COEF_W-1:0] hp_b0_reg, hp_a1_reg, hp_a2_reg;
    logic signed [COEF_W-1:0] lp_b0_reg, lp_a1_reg, lp_a2_reg;

    // sample histories and the current item
    logic signed [SAMPLE_BITS-1:0] x_reg, m_reg;
    logic signed [SAMPLE_BITS-1:0] in_hist1_reg, in_hist2_reg;
    logic signed [SAMPLE_BITS-1:0] mid_hist1_reg, mid_hist2_reg;
    logic signed [SAMPLE_BITS-1:0] out_hist1_reg, out_hist2_reg;

    // sequencer and datapath
    logic [1:0]              state_reg, state_next;
    logic [TERM_W-1:0]       term_reg, term_d_reg;
    logic                    sect_reg;
    logic                    prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                    out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic signed [COEF_W-1:0]      mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_smp;
    logic signed [ACC_W-1:0]       prod_ext, term_val;
    logic                          term_neg;
    logic signed [Q_W-1:0]         q_val;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic                          in_fire, sat_hold;

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign in_fire           = in_ch.valid && in_ch.ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = out_sample_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_b0_reg <= '0;
            hp_a1_reg <= '0;
            hp_a2_reg <= '0;
            lp_b0_reg <= '0;
            lp_a1_reg <= '0;
            lp_a2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HP_B0: hp_b0_reg <= cfg_data;
                REG_HP_A1: hp_a1_reg <= cfg_data;
                REG_HP_A2: hp_a2_reg <= cfg_data;
                REG_LP_B0: lp_b0_reg <= cfg_data;
                REG_LP_A1: lp_a1_reg <= cfg_data;
                REG_LP_A2: lp_a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_coef = hp_b0_reg;
        mul_smp  = x_reg;
        case (term_reg)
            TERM_X0:
            begin
                mul_coef = (sect_reg == SECT_HP) ? hp_b0_reg : lp_b0_reg;
                mul_smp  = (sect_reg == SECT_HP) ? x_reg : m_reg;
            end
            TERM_X1:
            begin
                mul_coef = (sect_reg == SECT_HP) ? hp_b0_reg : lp_b0_reg;
                mul_smp  = (sect_reg == SECT_HP) ? in_hist1_reg : mid_hist1_reg;
            end
            TERM_X2:
            begin
                mul_coef = (sect_reg == SECT_HP) ? hp_b0_reg : lp_b0_reg;
                mul_smp  = (sect_reg == SECT_HP) ? in_hist2_reg : mid_hist2_reg;
            end
            TERM_Y1:
            begin
                mul_coef = (sect_reg == SECT_HP) ? hp_a1_reg : lp_a1_reg;
                mul_smp  = (sect_reg == SECT_HP) ? mid_hist1_reg : out_hist1_reg;
            end
            TERM_Y2:
            begin
                mul_coef = (sect_reg == SECT_HP) ? hp_a2_reg : lp_a2_reg;
                mul_smp  = (sect_reg == SECT_HP) ? mid_hist2_reg : out_hist2_reg;
            end
            default: ;
        endcase
    end

    // scale and sign of the registered product
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        term_val = (term_d_reg == TERM_X1) ? (prod_ext <<< 1) : prod_ext;
        term_neg = ((term_d_reg == TERM_X1) && (sect_reg == SECT_HP))
                   || (term_d_reg == TERM_Y1) || (term_d_reg == TERM_Y2);
    end

    // round by shift, then clamp to the sample range
    always_comb
    begin
        q_val = Q_W'(acc_reg >>> COEF_FRAC_BITS);
        if (q_val > SAT_MAX)
            sat_val = SAT_MAX[SAMPLE_BITS-1:0];
        else if (q_val < SAT_MIN)
            sat_val = SAT_MIN[SAMPLE_BITS-1:0];
        else
            sat_val = q_val[SAMPLE_BITS-1:0];
    end

    // the low-pass result waits while the output register is still full
    assign sat_hold = (sect_reg == SECT_LP) && out_valid_reg && !out_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_MAC;
            ST_MAC:   if (term_reg == TERM_Y2) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_SAT;
            ST_SAT:
            begin
                if (sect_reg == SECT_HP)
                    state_next = ST_MAC;
                else if (!sat_hold)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            term_reg     <= TERM_X0;
            term_d_reg   <= TERM_X0;
            sect_reg     <= SECT_HP;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prod_vld_reg <= (state_reg == ST_MAC);
            if (state_reg == ST_MAC)
            begin
                term_d_reg <= term_reg;
                term_reg   <= term_reg + TERM_W'(1);
            end
            if (in_fire)
            begin
                term_reg <= TERM_X0;
                sect_reg <= SECT_HP;
            end
            else if ((state_reg == ST_SAT) && (sect_reg == SECT_HP))
            begin
                term_reg <= TERM_X0;
                sect_reg <= SECT_LP;
            end
        end
    end

    // multiplier, accumulator and current samples
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MAC)
            prod_reg <= PROD_W'(mul_coef) * PROD_W'(mul_smp);
        if (in_fire)
        begin
            x_reg   <= in_ch.sample_in;
            acc_reg <= ROUND_CONST;
        end
        else if ((state_reg == ST_SAT) && (sect_reg == SECT_HP))
        begin
            m_reg   <= sat_val;
            acc_reg <= ROUND_CONST;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= term_neg ? (acc_reg - term_val) : (acc_reg + term_val);
        end
    end

    // histories advance once the low-pass result is delivered to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hist1_reg  <= '0;
            in_hist2_reg  <= '0;
            mid_hist1_reg <= '0;
            mid_hist2_reg <= '0;
            out_hist1_reg <= '0;
            out_hist2_reg <= '0;
        end
        else if ((state_reg == ST_SAT) && (sect_reg == SECT_LP) && !sat_hold)
        begin
            in_hist2_reg  <= in_hist1_reg;
            in_hist1_reg  <= x_reg;
            mid_hist2_reg <= mid_hist1_reg;
            mid_hist1_reg <= m_reg;
            out_hist2_reg <= out_hist1_reg;
            out_hist1_reg <= sat_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_SAT) && (sect_reg == SECT_LP) && !sat_hold)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SAT) && (sect_reg == SECT_LP) && !sat_hold)
            out_sample_reg <= sat_val;
    end

endmodule
